>>> hdl/m3i_pkg.sv
// shared widths, payload structs and queue entry type for the 3x3 matrix inverse
package m3i_pkg;

	// element format
	localparam int DW = 32;
	localparam int FW = 16;

	// exact intermediate widths
	localparam int PW   = 2 * DW;         // product of two elements
	localparam int CW   = PW + 1;         // cofactor, signed
	localparam int DETW = DW + CW;        // determinant, signed
	localparam int ACW  = CW - 1;         // cofactor magnitude
	localparam int AW   = DETW - 1;       // determinant magnitude

	// divider widths: numerator 2*|C|*2^(2F) + |D|, denominator 2*|D|
	localparam int XW0   = ACW + 2 * FW + 1;
	localparam int XW    = ((XW0 > AW + 1) ? XW0 : AW + 1) + 1;
	localparam int QB    = DW;            // quotient bits, top bit flags saturation
	localparam int CMPW  = XW + QB - 1;
	localparam int DIV_LAT = QB + 1;      // operand stage plus one stage per bit

	// queue between front and back
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic signed [DW-1:0] a00;
		logic signed [DW-1:0] a01;
		logic signed [DW-1:0] a02;
		logic signed [DW-1:0] a10;
		logic signed [DW-1:0] a11;
		logic signed [DW-1:0] a12;
		logic signed [DW-1:0] a20;
		logic signed [DW-1:0] a21;
		logic signed [DW-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [DW-1:0] inv00;
		logic signed [DW-1:0] inv01;
		logic signed [DW-1:0] inv02;
		logic signed [DW-1:0] inv10;
		logic signed [DW-1:0] inv11;
		logic signed [DW-1:0] inv12;
		logic signed [DW-1:0] inv20;
		logic signed [DW-1:0] inv21;
		logic signed [DW-1:0] inv22;
		logic                 singular;
	} inv_t;

	// adjugate entries (index r*3+c) and determinant of one matrix
	typedef struct packed {
		logic [8:0][CW-1:0] cof;
		logic [DETW-1:0]    det;
	} q_entry_t;

endpackage

>>> hdl/m3i_front.sv
// front end: accepts matrices, forms the adjugate and the determinant
module m3i_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      mat_valid,
	output logic                      mat_stall,
	input  m3i_pkg::mat_t             mat,
	input  logic [m3i_pkg::FIFO_AW:0] fifo_count,
	output logic                      push,
	output m3i_pkg::q_entry_t         push_data
);
	import m3i_pkg::*;

	logic signed [DW-1:0]   m [3][3];
	logic                   accept;
	logic [FIFO_AW+1:0]     used;
	logic                   v_s1, v_s2, v_s3;
	logic signed [PW-1:0]   pa_s1 [9];
	logic signed [PW-1:0]   pb_s1 [9];
	logic signed [DW-1:0]   row0_s1 [3];
	logic signed [DW-1:0]   row0_s2 [3];
	logic [CW-1:0]          cof_s2 [9];
	logic [CW-1:0]          cof_s3 [9];
	logic signed [CW-1:0]   pl_s3 [3];
	logic signed [CW-1:0]   ph_s3 [3];
	logic signed [DETW-1:0] det_sum;

	assign m[0][0] = mat.a00;
	assign m[0][1] = mat.a01;
	assign m[0][2] = mat.a02;
	assign m[1][0] = mat.a10;
	assign m[1][1] = mat.a11;
	assign m[1][2] = mat.a12;
	assign m[2][0] = mat.a20;
	assign m[2][1] = mat.a21;
	assign m[2][2] = mat.a22;

	// credit check: every request in flight has a queue slot reserved
	assign used = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(v_s1) + (FIFO_AW+2)'(v_s2)
		+ (FIFO_AW+2)'(v_s3);
	assign mat_stall = (used >= (FIFO_AW+2)'(FIFO_DEPTH));
	assign accept = mat_valid && !mat_stall;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: the two 2x2 minor products of each cofactor
	for (genvar r = 0; r < 3; r++) begin : g_r
		for (genvar c = 0; c < 3; c++) begin : g_c
			localparam int R0 = (c + 1) % 3;
			localparam int R1 = (c + 2) % 3;
			localparam int C0 = (r + 1) % 3;
			localparam int C1 = (r + 2) % 3;
			always_ff @(posedge clk) begin
				pa_s1[r*3+c] <= m[R0][C0] * m[R1][C1];
				pb_s1[r*3+c] <= m[R0][C1] * m[R1][C0];
			end
		end
	end

	// stage 2: cofactors
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			cof_s2[k] <= {pa_s1[k][PW-1], pa_s1[k]} - {pb_s1[k][PW-1], pb_s1[k]};
		end
		for (int j = 0; j < 3; j++) begin
			row0_s1[j] <= m[0][j];
			row0_s2[j] <= row0_s1[j];
		end
	end

	// stage 3: row 0 times its cofactors, split into low and high halves
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			pl_s3[j] <= row0_s2[j] * $signed({1'b0, cof_s2[3*j][DW-1:0]});
			ph_s3[j] <= row0_s2[j] * $signed(cof_s2[3*j][CW-1:DW]);
		end
		for (int k = 0; k < 9; k++) begin
			cof_s3[k] <= cof_s2[k];
		end
	end

	// determinant: recombine halves and sum
	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + (DETW'(ph_s3[j]) <<< DW) + DETW'(pl_s3[j]);
		end
	end

	assign push = v_s3;
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			push_data.cof[k] = cof_s3[k];
		end
		push_data.det = det_sum;
	end

endmodule

>>> hdl/m3i_fifo.sv
// short queue that decouples the front end from the divider back end
module m3i_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  m3i_pkg::q_entry_t         push_data,
	input  logic                      pop,
	output m3i_pkg::q_entry_t         head,
	output logic                      empty,
	output logic [m3i_pkg::FIFO_AW:0] count
);
	import m3i_pkg::*;

	q_entry_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

>>> hdl/m3i_div.sv
// pipelined restoring divider: rounded, saturated quotient of one inverse element
module m3i_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [m3i_pkg::ACW-1:0]       absc,
	input  logic [m3i_pkg::AW-1:0]        absd,
	input  logic                          neg,
	output logic signed [m3i_pkg::DW-1:0] res
);
	import m3i_pkg::*;

	logic [XW-1:0] rem_s [QB];
	logic [XW-1:0] y_s   [QB];
	logic [QB-1:0] q_s   [QB+1];
	logic          neg_s [QB+1];
	logic          sat;
	logic [DW-1:0] mag;

	// operand stage: numerator 2|N|+|D|, denominator 2|D|
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (XW'(absc) << (2 * FW + 1)) + XW'(absd);
			y_s[0]   <= XW'(absd) << 1;
			q_s[0]   <= '0;
			neg_s[0] <= neg;
		end
	end

	// one quotient bit per stage, top bit first
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int B = QB - 1 - k;
		logic [CMPW-1:0] ysh;
		logic [CMPW-1:0] diff;
		logic            ge;

		assign ysh  = CMPW'(y_s[k]) << B;
		assign ge   = (CMPW'(rem_s[k]) >= ysh);
		assign diff = CMPW'(rem_s[k]) - ysh;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= q_s[k] | (QB'(ge) << B);
				neg_s[k+1] <= neg_s[k];
			end
		end

		if (k < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[XW-1:0] : rem_s[k];
					y_s[k+1]   <= y_s[k];
				end
			end
		end
	end

	// saturate on quotient of 2^(DW-1) or more, then apply sign
	assign sat = q_s[QB][QB-1];
	always_comb begin
		if (sat) begin
			mag = neg_s[QB] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			mag = {1'b0, q_s[QB][DW-2:0]};
		end
		res = neg_s[QB] ? $signed(~mag + 1'b1) : $signed(mag);
	end

endmodule

>>> hdl/m3i_back.sv
// back end: takes queued adjugates, divides by the determinant, holds the result
module m3i_back (
	input  logic              clk,
	input  logic              arst_n,
	input  m3i_pkg::q_entry_t head,
	input  logic              empty,
	output logic              pop,
	output logic              inv_valid,
	input  logic              inv_stall,
	output m3i_pkg::inv_t     inv
);
	import m3i_pkg::*;

	logic                 adv;
	logic                 v_s1;
	logic [ACW-1:0]       absc_s1 [9];
	logic [AW-1:0]        absd_s1;
	logic                 neg_s1 [9];
	logic                 zero_s1;
	logic                 vp_s [DIV_LAT];
	logic                 zp_s [DIV_LAT];
	logic signed [DW-1:0] res [9];
	logic                 out_v_q;
	inv_t                 inv_q;
	inv_t                 inv_d;
	logic [DETW-1:0]      negdet;

	// whole back end moves when the output register is free or being taken
	assign adv = !out_v_q || !inv_stall;
	assign pop = adv && !empty;
	assign negdet = -head.det;

	// stage 1: magnitudes, signs and the singular check
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				absc_s1[k] <= head.cof[k][CW-1] ? ACW'(-head.cof[k]) : ACW'(head.cof[k]);
				neg_s1[k]  <= head.cof[k][CW-1] ^ head.det[DETW-1];
			end
			absd_s1 <= head.det[DETW-1] ? negdet[AW-1:0] : head.det[AW-1:0];
			zero_s1 <= (head.det == '0);
			zp_s[0] <= zero_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				zp_s[i] <= zp_s[i-1];
			end
		end
	end

	// valid chain alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vp_s[i] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= !empty;
			vp_s[0] <= v_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				vp_s[i] <= vp_s[i-1];
			end
			out_v_q <= vp_s[DIV_LAT-1];
		end
	end

	// one divider per inverse element
	for (genvar k = 0; k < 9; k++) begin : g_div
		m3i_div u_div (
			.clk  (clk),
			.en   (adv),
			.absc (absc_s1[k]),
			.absd (absd_s1),
			.neg  (neg_s1[k]),
			.res  (res[k])
		);
	end

	// result assembly, zeros when singular
	always_comb begin
		logic z;
		z = zp_s[DIV_LAT-1];
		inv_d.inv00    = z ? '0 : res[0];
		inv_d.inv01    = z ? '0 : res[1];
		inv_d.inv02    = z ? '0 : res[2];
		inv_d.inv10    = z ? '0 : res[3];
		inv_d.inv11    = z ? '0 : res[4];
		inv_d.inv12    = z ? '0 : res[5];
		inv_d.inv20    = z ? '0 : res[6];
		inv_d.inv21    = z ? '0 : res[7];
		inv_d.inv22    = z ? '0 : res[8];
		inv_d.singular = z;
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			inv_q <= inv_d;
		end
	end

	assign inv_valid = out_v_q;
	assign inv       = inv_q;

endmodule

>>> hdl/matrix3x3_inverse.sv
// top level of the 3x3 matrix inverse
// Inverts one 3x3 matrix of signed Q16.16 elements per request by the adjugate
// method, exact up to one rounding (nearest, ties away from zero) with saturation
// of each element; a zero determinant gives singular set and all elements zero.
// Throughput is one matrix per clock while the output is not stalled. A request
// passes from acceptance to result through three front-end stages (minor
// products, cofactors, determinant products), the 8-entry queue, one
// sign/magnitude stage, the 33-stage divider pipeline (operand setup plus one
// stage per quotient bit, nine dividers side by side) and the output register.
// An output stall freezes the divider pipeline; the front end keeps accepting
// until its queue credits run out.
module matrix3x3_inverse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	output logic          mat_stall,
	input  m3i_pkg::mat_t mat,
	output logic          inv_valid,
	input  logic          inv_stall,
	output m3i_pkg::inv_t inv
);
	import m3i_pkg::*;

	logic             push;
	q_entry_t         push_data;
	logic             pop;
	q_entry_t         head;
	logic             empty;
	logic [FIFO_AW:0] fifo_count;

	// adjugate and determinant
	m3i_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat_valid  (mat_valid),
		.mat_stall  (mat_stall),
		.mat        (mat),
		.fifo_count (fifo_count),
		.push       (push),
		.push_data  (push_data)
	);

	// decoupling queue
	m3i_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.count     (fifo_count)
	);

	// division and output
	m3i_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.inv_valid (inv_valid),
		.inv_stall (inv_stall),
		.inv       (inv)
	);

endmodule

>>> hdl/m3i_checker.sv
// port-level checks for the 3x3 matrix inverse, bound to the top level
module m3i_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          mat_valid,
	input logic          mat_stall,
	input logic          inv_valid,
	input logic          inv_stall,
	input m3i_pkg::inv_t inv
);
	import m3i_pkg::*;

	logic [7:0] cnt_q;

	// requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 8'(mat_valid && !mat_stall) - 8'(inv_valid && !inv_stall);
		end
	end

	// a result needs an earlier request
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && !inv_stall) |-> (cnt_q != '0))
		else $error("result without outstanding request");

	// singular results carry all-zero elements
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && inv.singular) |-> (inv.inv00 == '0 && inv.inv01 == '0 &&
		inv.inv02 == '0 && inv.inv10 == '0 && inv.inv11 == '0 && inv.inv12 == '0 &&
		inv.inv20 == '0 && inv.inv21 == '0 && inv.inv22 == '0))
		else $error("singular result with nonzero element");

	// stalled result stays put
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && inv_stall) |=> inv_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(inv_valid && inv_stall) |=> $stable(inv))
		else $error("result changed while stalled");

endmodule

bind matrix3x3_inverse m3i_checker u_chk (.*);
